[design/mtchd_pkg.sv]
package mtchd_pkg;

    localparam int CHANNELS    = 10;
    localparam int MEDIAN_RANK = 4;
    localparam int POWER_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int FUDGE_WIDTH = 16;
    localparam int CHAN_W      = 4;
    localparam int IDX_W       = $clog2(CHANNELS);
    localparam int PROD_WIDTH  = POWER_WIDTH + FUDGE_WIDTH;
    localparam int MED_SEL     = (MEDIAN_RANK >= CHANNELS) ? CHANNELS - 1 : MEDIAN_RANK;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FUDGE_WIDTH-1:0] FUDGE_RESET = FUDGE_WIDTH'(750);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUDGE      = 2'd0,
        CFG_MASK       = 2'd1,
        CFG_IGNORE_ALL = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [POWER_WIDTH-1:0] power_0;
        logic [POWER_WIDTH-1:0] power_1;
        logic [POWER_WIDTH-1:0] power_2;
        logic [POWER_WIDTH-1:0] power_3;
        logic [POWER_WIDTH-1:0] power_4;
        logic [POWER_WIDTH-1:0] power_5;
        logic [POWER_WIDTH-1:0] power_6;
        logic [POWER_WIDTH-1:0] power_7;
        logic [POWER_WIDTH-1:0] power_8;
        logic [POWER_WIDTH-1:0] power_9;
        logic                   clear_hit;
        logic [CHAN_W-1:0]      count_channel;
    } in_word_t;

    typedef struct packed {
        logic                   hit_now;
        logic [CHAN_W-1:0]      strongest_channel;
        logic                   hit_flag;
        logic [CHAN_W-1:0]      last_hit_channel;
        logic [COUNT_WIDTH-1:0] selected_count;
    } out_word_t;

    typedef logic [CHANNELS-1:0][POWER_WIDTH-1:0] power_vec_t;

    typedef struct packed {
        logic [CHAN_W-1:0] rank;
        logic              is_max;
    } lane_res_t;

    typedef struct packed {
        logic [FUDGE_WIDTH-1:0] fudge;
        logic [CHANNELS-1:0]    mask;
        logic                   all;
    } cfg_t;

    typedef struct packed {
        logic mul;
        logic upd;
    } pipe_en_t;

endpackage

[design/median_threshold_channel_hit_detector.sv]
// Lanes, merge, multiply and update are each one registered stage between an accepted
// input word and m_data; throughput is one word per cycle unless m_ready stalls.
// Stalls on m_ready back up stage by stage, so s_ready stays high while any stage is empty.
// Reset: fudge factor 750, mask and ignore-all cleared, hit counters,
// sticky flag and last hit channel zeroed, pipeline emptied.
module median_threshold_channel_hit_detector import mtchd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic en1, en2;
    pipe_en_t pen;

    power_vec_t             power_in;
    power_vec_t             power1_reg;
    logic                   clear1_reg, clear2_reg;
    logic [CHAN_W-1:0]      cc1_reg, cc2_reg;
    lane_res_t              lanes [CHANNELS];
    logic [POWER_WIDTH-1:0] med;
    logic [POWER_WIDTH-1:0] maxv;
    logic [CHAN_W-1:0]      best;

    // configuration
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FUDGE:      cfg_next.fudge = cfg_data[FUDGE_WIDTH-1:0];
                CFG_MASK:       cfg_next.mask  = cfg_data[CHANNELS-1:0];
                CFG_IGNORE_ALL: cfg_next.all   = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fudge <= FUDGE_RESET;
            cfg_reg.mask  <= '0;
            cfg_reg.all   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline control
    always_comb begin
        rdy4    = !v4_reg || m_ready;
        rdy3    = !v3_reg || rdy4;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        en1     = s_valid && rdy1;
        en2     = v1_reg && rdy2;
        pen.mul = v2_reg && rdy3;
        pen.upd = v3_reg && rdy4;
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
        v4_next = rdy4 ? v3_reg  : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    // datapath
    assign power_in = {s_data.power_9, s_data.power_8, s_data.power_7, s_data.power_6,
                       s_data.power_5, s_data.power_4, s_data.power_3, s_data.power_2,
                       s_data.power_1, s_data.power_0};

    always_ff @(posedge aclk) begin
        if (en1) begin
            power1_reg <= power_in;
            clear1_reg <= s_data.clear_hit;
            cc1_reg    <= s_data.count_channel;
        end
        if (en2) begin
            clear2_reg <= clear1_reg;
            cc2_reg    <= cc1_reg;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mtchd_lane u_lane (
            .aclk     (aclk),
            .en       (en1),
            .lane_idx (CHAN_W'(g)),
            .power    (power_in),
            .res      (lanes[g])
        );
    end

    mtchd_merge u_merge (
        .aclk  (aclk),
        .en    (en2),
        .lanes (lanes),
        .power (power1_reg),
        .med   (med),
        .maxv  (maxv),
        .best  (best)
    );

    mtchd_hit u_hit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pen           (pen),
        .cfg           (cfg_reg),
        .med           (med),
        .maxv          (maxv),
        .best          (best),
        .clear_hit     (clear2_reg),
        .count_channel (cc2_reg),
        .word          (m_data)
    );

    a_hit_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit_now |-> m_data.hit_flag)
        else $error("hit without sticky flag");

    a_hit_records_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit_now |-> m_data.last_hit_channel == m_data.strongest_channel)
        else $error("hit channel not recorded");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

[design/mtchd_lane.sv]
module mtchd_lane import mtchd_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [CHAN_W-1:0] lane_idx,
    input  power_vec_t        power,
    output lane_res_t         res
);

    lane_res_t              res_reg;
    lane_res_t              res_next;
    logic [POWER_WIDTH-1:0] own;

    // stable rank: count smaller values, equal values at lower index first
    always_comb begin
        own = power[lane_idx[IDX_W-1:0]];
        res_next.rank = '0;
        res_next.is_max = 1'b1;
        for (int j = 0; j < CHANNELS; j++) begin
            if (CHAN_W'(j) != lane_idx) begin
                if (power[j] < own || (power[j] == own && CHAN_W'(j) < lane_idx)) begin
                    res_next.rank = res_next.rank + CHAN_W'(1);
                end
                if (CHAN_W'(j) < lane_idx) begin
                    if (!(own > power[j])) begin
                        res_next.is_max = 1'b0;
                    end
                end else begin
                    if (!(own >= power[j])) begin
                        res_next.is_max = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[design/mtchd_merge.sv]
module mtchd_merge import mtchd_pkg::*; (
    input  logic                   aclk,
    input  logic                   en,
    input  lane_res_t              lanes [CHANNELS],
    input  power_vec_t             power,
    output logic [POWER_WIDTH-1:0] med,
    output logic [POWER_WIDTH-1:0] maxv,
    output logic [CHAN_W-1:0]      best
);

    logic [POWER_WIDTH-1:0] med_reg;
    logic [POWER_WIDTH-1:0] med_next;
    logic [POWER_WIDTH-1:0] maxv_reg;
    logic [POWER_WIDTH-1:0] maxv_next;
    logic [CHAN_W-1:0]      best_reg;
    logic [CHAN_W-1:0]      best_next;

    // exactly one lane holds each rank and exactly one is the max
    always_comb begin
        med_next  = '0;
        maxv_next = '0;
        best_next = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (lanes[i].rank == CHAN_W'(MED_SEL)) begin
                med_next = med_next | power[i];
            end
            if (lanes[i].is_max) begin
                maxv_next = maxv_next | power[i];
                best_next = best_next | CHAN_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            med_reg  <= med_next;
            maxv_reg <= maxv_next;
            best_reg <= best_next;
        end
    end

    assign med  = med_reg;
    assign maxv = maxv_reg;
    assign best = best_reg;

endmodule

[design/mtchd_hit.sv]
module mtchd_hit import mtchd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pipe_en_t               pen,
    input  cfg_t                   cfg,
    input  logic [POWER_WIDTH-1:0] med,
    input  logic [POWER_WIDTH-1:0] maxv,
    input  logic [CHAN_W-1:0]      best,
    input  logic                   clear_hit,
    input  logic [CHAN_W-1:0]      count_channel,
    output out_word_t              word
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [PROD_WIDTH-1:0]  thresh_reg;
    logic [POWER_WIDTH-1:0] maxv_reg;
    logic [CHAN_W-1:0]      best_reg;
    logic                   clear_reg;
    logic [CHAN_W-1:0]      cc_reg;

    logic [COUNT_WIDTH-1:0] counts_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] counts_next [CHANNELS];
    logic                   sticky_reg;
    logic                   sticky_next;
    logic [CHAN_W-1:0]      last_reg;
    logic [CHAN_W-1:0]      last_next;
    out_word_t              word_reg;
    out_word_t              word_next;
    logic                   hit;

    always_ff @(posedge aclk) begin
        if (pen.mul) begin
            thresh_reg <= PROD_WIDTH'(med) * PROD_WIDTH'(cfg.fudge);
            maxv_reg   <= maxv;
            best_reg   <= best;
            clear_reg  <= clear_hit;
            cc_reg     <= count_channel;
        end
    end

    always_comb begin
        hit = !cfg.all && !cfg.mask[best_reg[IDX_W-1:0]]
              && (PROD_WIDTH'(maxv_reg) > thresh_reg);
        for (int i = 0; i < CHANNELS; i++) begin
            counts_next[i] = counts_reg[i];
            if (hit && best_reg == CHAN_W'(i) && counts_reg[i] != COUNT_MAX) begin
                counts_next[i] = counts_reg[i] + COUNT_WIDTH'(1);
            end
        end
        sticky_next = hit ? 1'b1 : (clear_reg ? 1'b0 : sticky_reg);
        last_next   = hit ? best_reg : last_reg;

        word_next.hit_now           = hit;
        word_next.strongest_channel = best_reg;
        word_next.hit_flag          = sticky_next;
        word_next.last_hit_channel  = last_next;
        if (cc_reg < CHAN_W'(CHANNELS)) begin
            word_next.selected_count = counts_next[cc_reg[IDX_W-1:0]];
        end else begin
            word_next.selected_count = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                counts_reg[i] <= '0;
            end
            sticky_reg <= 1'b0;
            last_reg   <= '0;
        end else if (pen.upd) begin
            counts_reg <= counts_next;
            sticky_reg <= sticky_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pen.upd) begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

[verif/median_threshold_channel_hit_detector_tb.sv]
module median_threshold_channel_hit_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtchd_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_WORDS  = 250;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_PRINTS   = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    class detector_scoreboard;
        logic [FUDGE_WIDTH-1:0] fudge;
        logic [CHANNELS-1:0]    mask;
        logic                   all_off;
        logic [COUNT_WIDTH-1:0] chan_hits [CHANNELS];
        logic                   sticky_flag;
        logic [CHAN_W-1:0]      last_ch;
        out_word_t              pending_results [$];
        int                     errors;

        function new();
            fudge       = FUDGE_RESET;
            mask        = '0;
            all_off     = 1'b0;
            foreach (chan_hits[i]) chan_hits[i] = '0;
            sticky_flag = 1'b0;
            last_ch     = '0;
            errors      = 0;
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FUDGE:      fudge = d[FUDGE_WIDTH-1:0];
                CFG_MASK:       mask = d[CHANNELS-1:0];
                CFG_IGNORE_ALL: all_off = d[0];
                default: ;
            endcase
        endfunction

        function void note_vector(in_word_t w);
            power_vec_t             p;
            logic [POWER_WIDTH-1:0] sorted [CHANNELS];
            logic [POWER_WIDTH-1:0] v;
            logic [PROD_WIDTH-1:0]  thresh;
            int                     best;
            int                     j;
            out_word_t              r;
            p = {w.power_9, w.power_8, w.power_7, w.power_6, w.power_5,
                 w.power_4, w.power_3, w.power_2, w.power_1, w.power_0};
            best = 0;
            for (int i = 1; i < CHANNELS; i++) begin
                if (p[i] > p[best]) best = i;
            end
            for (int i = 0; i < CHANNELS; i++) begin
                v = p[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            thresh = PROD_WIDTH'(sorted[MED_SEL]) * PROD_WIDTH'(fudge);
            if (w.clear_hit) sticky_flag = 1'b0;
            r.hit_now = !mask[best] && (PROD_WIDTH'(p[best]) > thresh) && !all_off;
            if (r.hit_now) begin
                if (chan_hits[best] != '1) chan_hits[best]++;
                sticky_flag = 1'b1;
                last_ch     = CHAN_W'(best);
            end
            r.strongest_channel = CHAN_W'(best);
            r.hit_flag          = sticky_flag;
            r.last_hit_channel  = last_ch;
            if (w.count_channel < CHANNELS) begin
                r.selected_count = chan_hits[w.count_channel];
            end else begin
                r.selected_count = '0;
            end
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(out_word_t got);
            out_word_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result word %h with nothing pending", got));
                return;
            end
            want = pending_results.pop_front();
            compare_field("hit_now", got.hit_now, want.hit_now);
            compare_field("strongest_channel", got.strongest_channel, want.strongest_channel);
            compare_field("hit_flag", got.hit_flag, want.hit_flag);
            compare_field("last_hit_channel", got.last_hit_channel, want.last_hit_channel);
            compare_field("selected_count", got.selected_count, want.selected_count);
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    detector_scoreboard sb;
    int                 tx_max = 0;
    int                 rx_max = 0;
    bit                 hold_long = 1'b0;
    int unsigned        cycle_count = 0;

    median_threshold_channel_hit_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_vector(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (cfg_valid && cfg_ready) sb.apply_write(cfg_index, cfg_data);
        end
    end

    // result side: random stall per word, one long hold on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_long) begin
                stall     = HOLD_CYCLES;
                hold_long = 1'b0;
            end else begin
                stall = $urandom_range(0, rx_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    function automatic in_word_t pack_word(power_vec_t p, logic clr, logic [CHAN_W-1:0] cch);
        return {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], clr, cch};
    endfunction

    // mostly one peak over low noise, so hits and misses both show up
    function automatic in_word_t rand_word();
        power_vec_t        p;
        int                shift;
        int                pk;
        logic [CHAN_W-1:0] cch;
        case ($urandom_range(0, 9))
            0: begin
                for (int i = 0; i < CHANNELS; i++) p[i] = $urandom;
            end
            1: p = {CHANNELS{POWER_WIDTH'($urandom)}};
            default: begin
                shift = $urandom_range(8, 32);
                for (int i = 0; i < CHANNELS; i++) p[i] = $urandom >> shift;
                pk    = $urandom_range(0, CHANNELS - 1);
                p[pk] = $urandom >> $urandom_range(0, 20);
                if ($urandom_range(0, 4) == 0) p[$urandom_range(0, CHANNELS - 1)] = p[pk];
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            cch = CHAN_W'($urandom_range(0, 15));
        end else begin
            cch = CHAN_W'($urandom_range(0, CHANNELS - 1));
        end
        return pack_word(p, $urandom_range(0, 7) == 0, cch);
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(int n);
        repeat (n) send_word(rand_word());
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        power_vec_t p;
        in_word_t   w;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: fudge 750, nothing masked
        tx_max = 15;
        rx_max = 15;
        p = '0;
        send_word(pack_word(p, 1'b0, 4'd0));
        p = {CHANNELS{32'hFFFF_FFFF}};
        send_word(pack_word(p, 1'b0, 4'd9));
        p = '0;
        p[9] = '1;
        send_word(pack_word(p, 1'b0, 4'd9));
        p = {CHANNELS{32'd1}};
        p[0] = '1;
        send_word(pack_word(p, 1'b0, 4'd15));
        p = '0;
        p[4] = 32'h00AB_0000;
        p[7] = 32'h00AB_0000;
        send_word(pack_word(p, 1'b0, 4'd4));
        p = {CHANNELS{32'd5}};
        send_word(pack_word(p, 1'b1, 4'd4));
        p = '0;
        p[2] = 32'd100;
        send_word(pack_word(p, 1'b1, 4'd2));
        p = {CHANNELS{32'd1}};
        p[6] = 32'd750;
        send_word(pack_word(p, 1'b0, 4'd6));
        p[6] = 32'd751;
        send_word(pack_word(p, 1'b0, 4'd6));
        // lower median sits at rank 4, not 3 or 5
        p = {32'd1000, 32'd2, 32'd2, 32'd2, 32'd2, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0};
        send_word(pack_word(p, 1'b0, 4'd9));
        p = {32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd2, 32'd2, 32'd2, 32'd700};
        send_word(pack_word(p, 1'b0, 4'd0));
        for (int c = CHANNELS; c < 16; c++) begin
            w = rand_word();
            w.count_channel = CHAN_W'(c);
            send_word(w);
        end
        send_random(PHASE_WORDS);

        drain();
        cfg_write(CFG_FUDGE, 16'd0);
        cfg_write(CFG_MASK, {6'($urandom), 10'($urandom)});
        tx_max = $urandom_range(0, 1) ? 15 : 3;
        rx_max = $urandom_range(0, 1) ? 15 : 3;
        send_random(PHASE_WORDS);

        drain();
        cfg_write(CFG_FUDGE, 16'hFFFF);
        cfg_write(CFG_MASK, {6'($urandom), 10'd0});
        tx_max = 0;
        rx_max = 0;
        send_random(PHASE_WORDS);

        drain();
        cfg_write(CFG_FUDGE, 16'd1);
        cfg_write(CFG_MASK, {6'($urandom), 10'h3FF});
        cfg_write(CFG_UNMAPPED, 16'($urandom));
        // back up the pipeline against a stalled result side
        hold_long = 1'b1;
        tx_max    = 0;
        rx_max    = 15;
        send_random(40);
        tx_max = 15;
        rx_max = 3;
        send_random(PHASE_WORDS);

        drain();
        cfg_write(CFG_FUDGE, 16'($urandom_range(2, 50)));
        cfg_write(CFG_MASK, {6'($urandom), 10'($urandom)});
        cfg_write(CFG_IGNORE_ALL, {15'($urandom), 1'b1});
        tx_max = 3;
        rx_max = 15;
        send_random(PHASE_WORDS);

        drain();
        cfg_write(CFG_FUDGE, 16'($urandom));
        cfg_write(CFG_MASK, {6'($urandom), 10'd0});
        cfg_write(CFG_IGNORE_ALL, {15'($urandom), 1'b0});
        tx_max = $urandom_range(0, 1) ? 15 : 0;
        rx_max = $urandom_range(0, 1) ? 15 : 0;
        send_random(PHASE_WORDS);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
